[src/tsp_pkg.sv]
// Package: types, constants and microprogram of the temperature plausibility check.
`timescale 1ns / 1ps
`default_nettype none
package tsp_pkg;

    localparam int SAMPLES_DEF = 6;
    localparam int ADC_W       = 10;
    localparam int VAL_W       = 16;
    localparam int SUM_W       = 20;
    localparam int WIDE_W      = 40;
    localparam int CFG_IDX_W   = 2;
    localparam int STEP_W      = 4;
    localparam logic [VAL_W-1:0] SCALE_MUL = 16'd33000;
    localparam int SCALE_SHIFT = 10;

    localparam logic [VAL_W-1:0] LOW_RST    = 16'd800;
    localparam logic [VAL_W-1:0] SPREAD_RST = 16'd500;
    localparam logic [VAL_W-1:0] FAULT_RST  = 16'd9900;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW    = 2'd0,
        CFG_SPREAD = 2'd1,
        CFG_FAULT  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FC_OK     = 2'd0,
        FC_LOW    = 2'd1,
        FC_SPREAD = 2'd2
    } t_fault;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_SCALE,
        OP_STORE,
        OP_CLR,
        OP_READ,
        OP_SQ,
        OP_ACC,
        OP_NQ_SS,
        OP_LHS,
        OP_RHS,
        OP_CMP,
        OP_QN,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_CNT_MORE,
        JC_IDX_MORE
    } t_jc;

    typedef logic [STEP_W-1:0] t_step;

    typedef struct packed {
        t_op   op;
        logic  wait_in;
        logic  wait_out;
        t_jc   jc;
        t_step target;
    } t_uword;

    localparam t_step ST_WAIT  = 4'd0;
    localparam t_step ST_STORE = 4'd1;
    localparam t_step ST_CLR   = 4'd2;
    localparam t_step ST_READ  = 4'd3;
    localparam t_step ST_SQ    = 4'd4;
    localparam t_step ST_ACC   = 4'd5;
    localparam t_step ST_NQ_SS = 4'd6;
    localparam t_step ST_LHS   = 4'd7;
    localparam t_step ST_RHS   = 4'd8;
    localparam t_step ST_CMP   = 4'd9;
    localparam t_step ST_QN    = 4'd10;
    localparam t_step ST_EMIT  = 4'd11;

    // control store
    function automatic t_uword f_ucode(input t_step step);
        t_uword w;
        w = '{op: OP_NOP, wait_in: 1'b0, wait_out: 1'b0, jc: JC_ALWAYS, target: ST_WAIT};
        case (step)
            ST_WAIT:  w = '{OP_SCALE, 1'b1, 1'b0, JC_NEXT,     ST_WAIT};
            ST_STORE: w = '{OP_STORE, 1'b0, 1'b0, JC_CNT_MORE, ST_WAIT};
            ST_CLR:   w = '{OP_CLR,   1'b0, 1'b0, JC_NEXT,     ST_WAIT};
            ST_READ:  w = '{OP_READ,  1'b0, 1'b0, JC_NEXT,     ST_WAIT};
            ST_SQ:    w = '{OP_SQ,    1'b0, 1'b0, JC_NEXT,     ST_WAIT};
            ST_ACC:   w = '{OP_ACC,   1'b0, 1'b0, JC_IDX_MORE, ST_READ};
            ST_NQ_SS: w = '{OP_NQ_SS, 1'b0, 1'b0, JC_NEXT,     ST_WAIT};
            ST_LHS:   w = '{OP_LHS,   1'b0, 1'b0, JC_NEXT,     ST_WAIT};
            ST_RHS:   w = '{OP_RHS,   1'b0, 1'b0, JC_NEXT,     ST_WAIT};
            ST_CMP:   w = '{OP_CMP,   1'b0, 1'b0, JC_NEXT,     ST_WAIT};
            ST_QN:    w = '{OP_QN,    1'b0, 1'b0, JC_NEXT,     ST_WAIT};
            ST_EMIT:  w = '{OP_EMIT,  1'b0, 1'b1, JC_ALWAYS,   ST_WAIT};
            default:  w = '{OP_NOP,   1'b0, 1'b0, JC_ALWAYS,   ST_WAIT};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

[src/temperature_sensor_plausibility.sv]
// Top level: microcoded batch mean and spread check of temperature sensor samples.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_adc_sample
//  out     | output    | o_out_valid / i_out_ready  | o_temperature, o_fault_code
//  cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// Each item is accepted and scaled in the wait step, then stored and summed in the store step.
// After the last item of a batch the sequencer runs one clear step, then walks the store one
// entry at a time through read, square and accumulate steps, then NQ_SS, LHS, RHS, CMP, QN, EMIT.
// Reset (synchronous) clears the step counter, batch count, sum and output valid, and loads the config defaults.
// The final step holds while the output register is full and not taken.
`timescale 1ns / 1ps
`default_nettype none
module temperature_sensor_plausibility
    import tsp_pkg::*;
#(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire  [ADC_W-1:0]     i_adc_sample,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [VAL_W-1:0]     o_temperature,
    output logic [1:0]           o_fault_code,
    input  wire                  i_cfg_we,
    input  wire  [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [VAL_W-1:0]     i_cfg_data
);

    localparam int CW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam logic [CW-1:0]     LAST   = CW'(SAMPLES - 1);
    localparam logic [SUM_W-1:0]  RECIP  = SUM_W'((1 << SUM_W) / SAMPLES);
    localparam logic [WIDE_W-1:0] N_W    = WIDE_W'(SAMPLES);
    localparam logic [WIDE_W-1:0] NN1_W  = WIDE_W'(SAMPLES * (SAMPLES - 1));
    localparam logic [SUM_W:0]    N_S    = (SUM_W + 1)'(SAMPLES);

    logic [VAL_W-1:0]  r_low;
    logic [VAL_W-1:0]  r_spread;
    logic [VAL_W-1:0]  r_fault_val;

    logic [VAL_W-1:0]  r_store [SAMPLES];
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     r_idx;
    logic [SUM_W-1:0]  r_sum;
    logic [VAL_W-1:0]  r_rd;
    logic [WIDE_W-1:0] r_p;
    logic [WIDE_W-1:0] r_q;
    logic [WIDE_W-1:0] r_m;
    logic [SUM_W-1:0]  r_quot;
    logic              r_f_low;
    logic              r_f_spread;

    logic              r_out_valid;
    logic [VAL_W-1:0]  r_temp;
    t_fault            r_code;

    t_step             r_step;
    t_step             n_step;
    t_uword            cw;
    logic              in_acc;
    logic              out_free;
    logic              hold;
    logic              exec;
    logic [VAL_W-1:0]  scaled;
    logic [SUM_W-1:0]  rem;
    logic [VAL_W-1:0]  mean;
    t_fault            code;

    assign cw       = f_ucode(r_step);
    assign o_in_ready = cw.wait_in;
    assign in_acc   = i_in_valid && cw.wait_in;
    assign out_free = !r_out_valid || i_out_ready;
    assign hold     = (cw.wait_in && !in_acc) || (cw.wait_out && !out_free);
    assign exec     = !hold;
    assign scaled   = r_p[SCALE_SHIFT +: VAL_W];
    assign rem      = r_sum - r_p[SUM_W-1:0];
    assign mean     = ({1'b0, rem} >= N_S) ? VAL_W'(r_quot + 1'b1) : VAL_W'(r_quot);

    always_comb begin
        if (r_f_low) begin
            code = FC_LOW;
        end else if (r_f_spread) begin
            code = FC_SPREAD;
        end else begin
            code = FC_OK;
        end
    end

    always_comb begin
        n_step = r_step;
        if (exec) begin
            case (cw.jc)
                JC_NEXT:     n_step = r_step + 1'b1;
                JC_ALWAYS:   n_step = cw.target;
                JC_CNT_MORE: n_step = (r_cnt != LAST) ? cw.target : r_step + 1'b1;
                JC_IDX_MORE: n_step = (r_idx != LAST) ? cw.target : r_step + 1'b1;
                default:     n_step = ST_WAIT;
            endcase
        end
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_WAIT;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_low       <= LOW_RST;
            r_spread    <= SPREAD_RST;
            r_fault_val <= FAULT_RST;
        end else begin
            r_step <= n_step;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOW:    r_low       <= i_cfg_data;
                    CFG_SPREAD: r_spread    <= i_cfg_data;
                    CFG_FAULT:  r_fault_val <= i_cfg_data;
                    default:    ;
                endcase
            end
            if (exec && cw.op == OP_STORE) begin
                r_sum <= r_sum + SUM_W'(scaled);
                r_cnt <= (r_cnt == LAST) ? '0 : r_cnt + 1'b1;
            end
            if (exec && cw.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
                r_sum       <= '0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (exec) begin
            case (cw.op)
                OP_SCALE: r_p <= WIDE_W'(26'(i_adc_sample) * 26'(SCALE_MUL));
                OP_STORE: r_store[r_cnt] <= scaled;
                OP_CLR: begin
                    r_q   <= '0;
                    r_idx <= '0;
                end
                OP_READ:  r_rd <= r_store[r_idx];
                OP_SQ:    r_p <= WIDE_W'(32'(r_rd) * 32'(r_rd));
                OP_ACC: begin
                    r_q   <= r_q + r_p;
                    r_idx <= r_idx + 1'b1;
                end
                OP_NQ_SS: begin
                    r_q <= r_q * N_W;
                    r_p <= WIDE_W'(r_sum) * WIDE_W'(r_sum);
                end
                OP_LHS: begin
                    r_q <= (r_q >= r_p) ? r_q - r_p : '0;
                    r_p <= WIDE_W'(32'(r_spread) * 32'(r_spread));
                end
                OP_RHS: begin
                    r_p     <= r_p * NN1_W;
                    r_m     <= WIDE_W'(r_sum) * WIDE_W'(RECIP);
                    r_f_low <= {1'b0, r_sum} < (SUM_W + 1)'(r_low * N_S);
                end
                OP_CMP: begin
                    r_f_spread <= r_q > r_p;
                    r_quot     <= r_m[SUM_W +: SUM_W];
                end
                OP_QN:    r_p <= WIDE_W'(r_quot) * N_W;
                OP_EMIT: begin
                    r_temp <= (code == FC_OK) ? mean : r_fault_val;
                    r_code <= code;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_temperature = r_temp;
    assign o_fault_code  = r_code;

endmodule
`default_nettype wire

[bench/temperature_sensor_plausibility_tb.sv]
// Testbench: batch mean and spread check of the temperature sensor block, with scoreboard.
`timescale 1ns / 1ps
module temperature_sensor_plausibility_tb;
    import tsp_pkg::*;

    localparam int                BATCH         = SAMPLES_DEF;
    localparam longint unsigned   BATCH_N       = SAMPLES_DEF;
    localparam int unsigned       FULL_SCALE_CD = 33000;
    localparam int                SETTLE_CYCLES = 3 * SAMPLES_DEF + 16;
    localparam int                PHASE_ITEMS   = 150;
    localparam int                HOLD_CYCLES   = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

    typedef struct packed {
        logic [VAL_W-1:0] temp;
        t_fault           code;
    } t_reading;

    class t_batch_scoreboard;
        logic [VAL_W-1:0] low_lim;
        logic [VAL_W-1:0] spread_lim;
        logic [VAL_W-1:0] fault_val;
        logic [VAL_W-1:0] batch[BATCH];
        int unsigned      batch_len;
        logic [SUM_W-1:0] batch_sum;
        t_reading         expected_readings[$];
        int               errors;
        int               n_samples;
        int               n_results;
        int               code_hits[3];

        function new();
            low_lim    = LOW_RST;
            spread_lim = SPREAD_RST;
            fault_val  = FAULT_RST;
            foreach (batch[i]) batch[i] = '0;
            batch_len  = 0;
            batch_sum  = '0;
            errors     = 0;
            n_samples  = 0;
            n_results  = 0;
            foreach (code_hits[i]) code_hits[i] = 0;
        endfunction

        function logic [VAL_W-1:0] scaled(logic [ADC_W-1:0] raw);
            logic [31:0] prod;
            prod = 32'(raw) * FULL_SCALE_CD;
            return prod[10 +: VAL_W];
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
            case (idx)
                CFG_LOW:    low_lim    = data;
                CFG_SPREAD: spread_lim = data;
                CFG_FAULT:  fault_val  = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        function void note_sample(logic [ADC_W-1:0] raw);
            logic [VAL_W-1:0] cd;
            longint unsigned  s;
            longint unsigned  q;
            longint unsigned  lhs;
            longint unsigned  rhs;
            longint unsigned  lim;
            t_reading         want;
            cd = scaled(raw);
            n_samples++;
            if (batch_len < BATCH) batch[batch_len] = cd;
            batch_len++;
            batch_sum = batch_sum + SUM_W'(cd);
            if (batch_len < BATCH) return;
            s = 64'(batch_sum);
            q = 0;
            foreach (batch[i]) q += 64'(batch[i]) * 64'(batch[i]);
            lhs = BATCH_N * q;
            lhs = (lhs >= s * s) ? lhs - s * s : 64'd0;
            lim = 64'(spread_lim);
            rhs = BATCH_N * (BATCH_N - 1) * lim * lim;
            // low mean is tested on the exact sum and takes priority
            if (s < 64'(low_lim) * BATCH_N) begin
                want.temp = fault_val;
                want.code = FC_LOW;
            end else if (lhs > rhs) begin
                want.temp = fault_val;
                want.code = FC_SPREAD;
            end else begin
                want.temp = VAL_W'(s / BATCH_N);
                want.code = FC_OK;
            end
            expected_readings.push_back(want);
            batch_len = 0;
            batch_sum = '0;
        endfunction

        function void check_reading(logic [VAL_W-1:0] temp, logic [1:0] code);
            t_reading want;
            n_results++;
            if (expected_readings.size() == 0) begin
                $error("temperature: expected none, actual %0d (fault_code %0d)", temp, code);
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            if (temp !== want.temp) begin
                $error("temperature: expected %0d, actual %0d", want.temp, temp);
                errors++;
            end
            if (code !== want.code) begin
                $error("fault_code: expected %0d, actual %0d", want.code, code);
                errors++;
            end
            code_hits[want.code]++;
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [ADC_W-1:0]     i_adc_sample;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [VAL_W-1:0]     o_temperature;
    logic [1:0]           o_fault_code;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [VAL_W-1:0]     i_cfg_data;

    t_batch_scoreboard    mean_sb = new();
    bit                   gaps_on = 1'b1;
    bit                   hold_req = 1'b0;
    int                   hold_left = 0;

    temperature_sensor_plausibility i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_adc_sample  (i_adc_sample),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_temperature (o_temperature),
        .o_fault_code  (o_fault_code),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
                mean_sb.check_reading(o_temperature, o_fault_code);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !(gaps_on && $urandom_range(0, 99) < 10);
            end
        end
    end

    task automatic offer_sample(input logic [ADC_W-1:0] raw);
        while (gaps_on && $urandom_range(0, 99) < 10) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_adc_sample <= raw;
        do @(posedge i_clk); while (!o_in_ready);
        mean_sb.note_sample(raw);
    endtask

    task automatic configure(input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] sp,
                             input logic [VAL_W-1:0] fv);
        logic [VAL_W-1:0] junk;
        junk = VAL_W'($urandom);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LOW;
        i_cfg_data <= lo;
        @(posedge i_clk);
        mean_sb.set_reg(CFG_LOW, lo);
        i_cfg_idx  <= CFG_SPREAD;
        i_cfg_data <= sp;
        @(posedge i_clk);
        mean_sb.set_reg(CFG_SPREAD, sp);
        i_cfg_idx  <= CFG_FAULT;
        i_cfg_data <= fv;
        @(posedge i_clk);
        mean_sb.set_reg(CFG_FAULT, fv);
        // unused index must be ignored
        i_cfg_idx  <= CFG_SPARE;
        i_cfg_data <= junk;
        @(posedge i_clk);
        mean_sb.set_reg(CFG_SPARE, junk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic wait_results(input bit settle);
        while (mean_sb.pending() != 0) @(posedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic offer_random_batch();
        int centre;
        int amp;
        int v;
        centre = $urandom_range(0, 1023);
        case ($urandom_range(0, 4))
            0: amp = 0;
            1: amp = 3;
            2: amp = 15;
            3: amp = 40;
            default: amp = 1023;
        endcase
        repeat (BATCH) begin
            v = centre + int'($urandom_range(0, 2 * amp)) - amp;
            if (v < 0) v = 0;
            else if (v > 1023) v = 1023;
            offer_sample(ADC_W'(v));
        end
    endtask

    // batches sitting on the low limit: exact, just below, or with a tiny spread
    task automatic offer_bound_batch(input int raw);
        int kind;
        int odd_pos;
        kind    = $urandom_range(0, 2);
        odd_pos = $urandom_range(0, BATCH - 1);
        for (int k = 0; k < BATCH; k++) begin
            if (kind == 1) offer_sample(ADC_W'(raw - 1));
            else if (kind == 2 && k == odd_pos) offer_sample(ADC_W'(raw + 1));
            else offer_sample(ADC_W'(raw));
        end
    endtask

    initial begin
        int sent;
        int bound_raw;
        bit paused;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_adc_sample <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_LOW;
        i_cfg_data   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: dead sensor, full scale, floating input, both faults
        repeat (BATCH) offer_sample(10'd0);
        repeat (BATCH) offer_sample(10'd1023);
        for (int k = 0; k < BATCH; k++) offer_sample(k[0] ? 10'd1023 : 10'd0);
        i_in_valid <= 1'b0;
        wait_results(1'b1);
        configure(16'hFFFF, 16'd0, 16'h5A5A);
        for (int k = 0; k < BATCH; k++) offer_sample(k[0] ? 10'd0 : 10'd1023);
        i_in_valid <= 1'b0;
        wait_results(1'b1);

        for (int p = 0; p < 10; p++) begin
            bound_raw = $urandom_range(1, 1022);
            case (p)
                0: configure(LOW_RST, SPREAD_RST, FAULT_RST);
                1: configure(16'd0, 16'd0, 16'd0);
                2: configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: configure(16'd0, 16'hFFFF, VAL_W'($urandom));
                4: configure(mean_sb.scaled(ADC_W'(bound_raw)), 16'd0, VAL_W'($urandom));
                default: configure(VAL_W'($urandom_range(0, 33000)),
                                   VAL_W'($urandom_range(0, 1500)), VAL_W'($urandom));
            endcase
            gaps_on = (p != 5);
            if (p == 5) hold_req = 1'b1;
            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_ITEMS) begin
                if (p == 3 && !paused && sent >= 60) begin
                    paused = 1'b1;
                    i_in_valid <= 1'b0;
                    wait_results(1'b0);
                end
                if (p == 4) begin
                    offer_bound_batch(bound_raw);
                    sent += BATCH;
                end else if ($urandom_range(0, 99) < 8) begin
                    offer_sample(ADC_W'($urandom));
                    sent++;
                end else begin
                    offer_random_batch();
                    sent += BATCH;
                end
            end
            // close any open batch so the next settings start clean
            while (mean_sb.batch_len != 0) offer_sample(ADC_W'($urandom));
            i_in_valid <= 1'b0;
            wait_results(1'b1);
        end

        $display("Covered %0d samples and %0d batch results over 11 register settings",
                 mean_sb.n_samples, mean_sb.n_results);
        $display("Results by code: valid %0d, low mean %0d, wide spread %0d",
                 mean_sb.code_hits[FC_OK], mean_sb.code_hits[FC_LOW],
                 mean_sb.code_hits[FC_SPREAD]);
        if (mean_sb.errors == 0 && mean_sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[temperature_sensor_plausibility.f]
src/tsp_pkg.sv
src/temperature_sensor_plausibility.sv
bench/temperature_sensor_plausibility_tb.sv
